// ===== src/wcp_pkg.sv =====
// Shared types and constants of the WAV chunk parser.
package wcp_pkg;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_MALFORMED   = 2'd1,
		ST_UNSUPPORTED = 2'd2
	} status_t;

	typedef enum logic {
		KIND_PCM    = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEADER    = 2'd0,
		PH_CHUNK_HDR = 2'd1,
		PH_BODY      = 2'd2,
		PH_PAD       = 2'd3
	} phase_t;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam logic [31:0] FMT_MIN_LEN   = 32'd16;
	localparam logic [15:0] FMT_CODE_PCM  = 16'd1;
	localparam logic [15:0] REQUIRED_BITS = 16'd16;
	localparam logic [3:0]  HEADER_LAST   = 4'd11;
	localparam logic [2:0]  CHUNK_HDR_LAST = 3'd7;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       end_of_file;
	} in_item_t;

	typedef struct packed {
		kind_t       item_kind;
		logic [7:0]  pcm_byte;
		logic        data_restart;
		status_t     status;
		logic [15:0] channel_count;
		logic [31:0] rate_hz;
		logic [15:0] sample_bits;
	} out_item_t;

	// Results of one processed byte, written into the output queue in order.
	typedef struct packed {
		logic [1:0] cnt;
		out_item_t  first;
		out_item_t  second;
	} push_t;

endpackage

// ===== src/wcp_parser.sv =====
// Chunk walking state and per-byte decode logic of the WAV chunk parser.
module wcp_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  wcp_pkg::in_item_t item,
	output wcp_pkg::push_t   push
);

	typedef struct packed {
		wcp_pkg::phase_t  phase;
		logic [3:0]       hdr_cnt;
		logic             hdr_ok;
		logic [2:0]       tag_cnt;
		logic [31:0]      tag;
		logic [31:0]      len;
		logic [31:0]      left;
		logic [4:0]       off;
		logic [15:0]      fmt_code;
		logic [15:0]      p_ch;
		logic [31:0]      p_rate;
		logic [15:0]      p_bits;
		logic [15:0]      k_ch;
		logic [31:0]      k_rate;
		logic [15:0]      k_bits;
		logic             fmt_seen;
		logic             pcm_present;
		wcp_pkg::status_t err;
	} pstate_t;

	// State of a parser that waits for the first byte of a RIFF header.
	localparam pstate_t RESET_STATE = '{
		phase: wcp_pkg::PH_HEADER,
		hdr_ok: 1'b1,
		err: wcp_pkg::ST_OK,
		default: '0
	};

	pstate_t st_q;
	pstate_t st_d;

	function automatic logic [7:0] tag_byte(logic [31:0] word, logic [1:0] i);
		logic [7:0] r;
		case (i)
			2'd0: r = word[31:24];
			2'd1: r = word[23:16];
			2'd2: r = word[15:8];
			default: r = word[7:0];
		endcase
		return r;
	endfunction

	function automatic pstate_t enter_hdr(pstate_t s);
		pstate_t r;
		r = s;
		r.phase = wcp_pkg::PH_CHUNK_HDR;
		r.tag_cnt = '0;
		r.tag = '0;
		r.len = '0;
		return r;
	endfunction

	function automatic pstate_t finish_chunk(pstate_t s);
		pstate_t r;
		logic stop;
		r = s;
		stop = 1'b0;
		if (r.tag == wcp_pkg::TAG_FMT) begin
			if (r.fmt_code != wcp_pkg::FMT_CODE_PCM) begin
				r.err = wcp_pkg::ST_UNSUPPORTED;
				stop = 1'b1;
			end else begin
				r.k_ch = r.p_ch;
				r.k_rate = r.p_rate;
				r.k_bits = r.p_bits;
				r.fmt_seen = 1'b1;
			end
		end else if (r.tag == wcp_pkg::TAG_DATA) begin
			r.pcm_present = (r.len != '0);
		end
		if (!stop) begin
			if (r.len[0]) begin
				r.phase = wcp_pkg::PH_PAD;
			end else begin
				r = enter_hdr(r);
			end
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= RESET_STATE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		pstate_t nx;
		logic [7:0] b;
		logic pcm_v;
		logic restart;
		wcp_pkg::status_t fin;
		wcp_pkg::out_item_t pcm_item;
		wcp_pkg::out_item_t stat_item;

		b = item.file_byte;
		nx = st_q;
		pcm_v = 1'b0;
		restart = 1'b0;

		if (go && (st_q.err == wcp_pkg::ST_OK)) begin
			case (st_q.phase)
				wcp_pkg::PH_HEADER: begin
					if (!st_q.hdr_cnt[3] && !st_q.hdr_cnt[2] &&
					    (b != tag_byte(wcp_pkg::TAG_RIFF, st_q.hdr_cnt[1:0])))
						nx.hdr_ok = 1'b0;
					if (st_q.hdr_cnt[3] &&
					    (b != tag_byte(wcp_pkg::TAG_WAVE, st_q.hdr_cnt[1:0])))
						nx.hdr_ok = 1'b0;
					nx.hdr_cnt = st_q.hdr_cnt + 4'd1;
					if (st_q.hdr_cnt == wcp_pkg::HEADER_LAST) begin
						if (!nx.hdr_ok) begin
							nx.err = wcp_pkg::ST_MALFORMED;
						end else begin
							nx = enter_hdr(nx);
						end
					end
				end
				wcp_pkg::PH_CHUNK_HDR: begin
					// Four tag bytes, big end first, then a little-endian length.
					if (!st_q.tag_cnt[2]) begin
						nx.tag = {st_q.tag[23:0], b};
					end else begin
						case (st_q.tag_cnt[1:0])
							2'd0: nx.len[7:0] = st_q.len[7:0] | b;
							2'd1: nx.len[15:8] = st_q.len[15:8] | b;
							2'd2: nx.len[23:16] = st_q.len[23:16] | b;
							default: nx.len[31:24] = st_q.len[31:24] | b;
						endcase
					end
					nx.tag_cnt = st_q.tag_cnt + 3'd1;
					if (st_q.tag_cnt == wcp_pkg::CHUNK_HDR_LAST) begin
						nx.left = nx.len;
						if ((nx.tag == wcp_pkg::TAG_FMT) && (nx.len < wcp_pkg::FMT_MIN_LEN)) begin
							nx.err = wcp_pkg::ST_MALFORMED;
						end else if (nx.len == '0) begin
							nx = finish_chunk(nx);
						end else begin
							nx.phase = wcp_pkg::PH_BODY;
							nx.off = '0;
						end
					end
				end
				wcp_pkg::PH_BODY: begin
					if (st_q.tag == wcp_pkg::TAG_FMT) begin
						case (st_q.off)
							5'd0: nx.fmt_code[7:0] = b;
							5'd1: nx.fmt_code[15:8] = b;
							5'd2: nx.p_ch[7:0] = b;
							5'd3: nx.p_ch[15:8] = b;
							5'd4: nx.p_rate[7:0] = b;
							5'd5: nx.p_rate[15:8] = b;
							5'd6: nx.p_rate[23:16] = b;
							5'd7: nx.p_rate[31:24] = b;
							5'd14: nx.p_bits[7:0] = b;
							5'd15: nx.p_bits[15:8] = b;
							default: ;
						endcase
					end else if (st_q.tag == wcp_pkg::TAG_DATA) begin
						pcm_v = 1'b1;
						restart = (st_q.off == '0);
					end
					// The offset only matters up to the end of the fmt fields.
					if (!st_q.off[4])
						nx.off = st_q.off + 5'd1;
					nx.left = st_q.left - 32'd1;
					if (st_q.left == 32'd1)
						nx = finish_chunk(nx);
				end
				default: begin
					nx = enter_hdr(nx);
				end
			endcase
		end

		// Final status, judged on the state after this byte.
		fin = nx.err;
		if (nx.err == wcp_pkg::ST_OK) begin
			if ((nx.phase == wcp_pkg::PH_HEADER) ||
			    ((nx.phase == wcp_pkg::PH_BODY) && (nx.left != '0)))
				fin = wcp_pkg::ST_MALFORMED;
			else if (!nx.fmt_seen || !nx.pcm_present)
				fin = wcp_pkg::ST_MALFORMED;
			else if ((nx.k_bits != wcp_pkg::REQUIRED_BITS) || (nx.k_ch == '0) ||
			         (nx.k_rate == '0))
				fin = wcp_pkg::ST_UNSUPPORTED;
		end

		pcm_item.item_kind = wcp_pkg::KIND_PCM;
		pcm_item.pcm_byte = b;
		pcm_item.data_restart = restart;
		pcm_item.status = wcp_pkg::ST_OK;
		pcm_item.channel_count = st_q.k_ch;
		pcm_item.rate_hz = st_q.k_rate;
		pcm_item.sample_bits = st_q.k_bits;

		stat_item.item_kind = wcp_pkg::KIND_STATUS;
		stat_item.pcm_byte = '0;
		stat_item.data_restart = 1'b0;
		stat_item.status = fin;
		stat_item.channel_count = nx.k_ch;
		stat_item.rate_hz = nx.k_rate;
		stat_item.sample_bits = nx.k_bits;

		push.cnt = {1'b0, pcm_v} + {1'b0, go & item.end_of_file};
		push.first = pcm_v ? pcm_item : stat_item;
		push.second = stat_item;

		// End of file returns the parser to its reset state for the next file.
		st_d = (go && item.end_of_file) ? RESET_STATE : nx;
	end

endmodule

// ===== src/wcp_out_queue.sv =====
// Result queue of the WAV chunk parser: takes up to two items a cycle, delivers one unless stalled.
module wcp_out_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wcp_pkg::push_t     push,
	output logic               room2,
	output logic               valid,
	input  logic               stall,
	output wcp_pkg::out_item_t item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

	wcp_pkg::out_item_t mem [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] wr1;
	logic [PW-1:0] wr2;
	logic          pop;

	function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	assign wr1 = inc(wr_q);
	assign wr2 = inc(wr1);
	assign valid = (count_q != '0);
	assign pop = valid && !stall;
	assign item = mem[rd_q];
	assign room2 = (count_q <= ROOM_LIMIT);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem[wr_q] <= push.first;
		if (push.cnt == 2'd2)
			mem[wr1] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			case (push.cnt)
				2'd1: wr_q <= wr1;
				2'd2: wr_q <= wr2;
				default: ;
			endcase
			if (pop)
				rd_q <= inc(rd_q);
			count_q <= count_q + CW'(push.cnt) - CW'(pop);
		end
	end

endmodule

// ===== src/wav_chunk_parser.sv =====
// Top level of the byte-serial WAV (RIFF/WAVE) chunk parser.
//
// The byte channel (byte_valid, byte_stall, byte_item) carries one byte of a WAV
// file per transaction, with end_of_file set on the last byte. The result channel
// (result_valid, result_stall, result_item) carries one item per transaction:
// either a pcm byte from a data chunk body, with data_restart set on the first
// byte of each data chunk, or the final status item that closes every file.
// Each output item also carries the channels, rate and bits of the last good
// fmt chunk. A byte is taken into an input register, decoded by the parser
// once the queue has room for two items, and written into a small result
// queue, which offers its result. One byte is accepted every cycle while
// byte_stall is low; the final data byte of a file may give two
// items, which the queue absorbs. byte_stall rises only when the queue lacks
// room for two more items, so a stalled receiver holds back the input after the
// queue fills and nothing is lost. Reset clears the parser to expect a new RIFF
// header and empties the queue. After a status item the parser starts over, so
// files may follow one another directly.
module wav_chunk_parser #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  wcp_pkg::in_item_t  byte_item,
	output logic               result_valid,
	input  logic               result_stall,
	output wcp_pkg::out_item_t result_item
);

	logic              vld_s1;
	wcp_pkg::in_item_t item_s1;
	logic              room2;
	logic              go;
	wcp_pkg::push_t    push;

	// The held byte is decoded as soon as the queue can take both possible results.
	assign go = vld_s1 && room2;
	assign byte_stall = vld_s1 && !room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			vld_s1 <= 1'b1;
		end else if (go) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall)
			item_s1 <= byte_item;
	end

	wcp_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.push   (push)
	);

	wcp_out_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room2  (room2),
		.valid  (result_valid),
		.stall  (result_stall),
		.item   (result_item)
	);

endmodule

// ===== src/wcp_checker.sv =====
// Port-level checks of the WAV chunk parser, bound to its top level.
module wcp_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               byte_valid,
	input logic               byte_stall,
	input wcp_pkg::in_item_t  byte_item,
	input logic               result_valid,
	input logic               result_stall,
	input wcp_pkg::out_item_t result_item
);

	// A byte held back by the parser stays offered unchanged.
	a_byte_hold: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(byte_item))
		else $error("byte item changed while stalled");

	// A result held back by the receiver stays offered unchanged.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_item))
		else $error("result item changed while stalled");

	// With nothing queued the parser always has room, so input is never held.
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !byte_stall)
		else $error("input stalled while result queue is empty");

	// Pcm bytes never carry an error code.
	a_pcm_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_item.item_kind == wcp_pkg::KIND_PCM)
		|-> result_item.status == wcp_pkg::ST_OK)
		else $error("pcm item with nonzero status");

	// Status items carry no byte and no restart flag.
	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_item.item_kind == wcp_pkg::KIND_STATUS)
		|-> (result_item.pcm_byte == 8'd0) && !result_item.data_restart)
		else $error("status item with byte or restart set");

endmodule

bind wav_chunk_parser wcp_checker u_wcp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.byte_valid   (byte_valid),
	.byte_stall   (byte_stall),
	.byte_item    (byte_item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result_item  (result_item)
);

// ===== dv/wav_chunk_parser_tb.sv =====
// Testbench of the WAV chunk parser: random WAV files, predicted results, stalls on both sides.
`timescale 1ns / 100ps

module wav_chunk_parser_tb;

	typedef logic [7:0] byte_q_t[$];
	typedef enum {CK_FMT, CK_DATA, CK_OTHER} chunk_kind_t;

	// Follows the parser byte by byte and keeps the items it should produce, oldest first.
	class wav_result_board;
		wcp_pkg::out_item_t expected_items[$];
		int unsigned        failures;
		wcp_pkg::phase_t    phase;
		int                 hdr_cnt;
		int                 tag_cnt;
		bit                 hdr_good;
		bit                 fmt_seen;
		bit                 pcm_present;
		logic [31:0]        tag;
		logic [31:0]        len;
		logic [31:0]        left;
		logic [31:0]        new_rate;
		logic [31:0]        kept_rate;
		logic [15:0]        fmt_code;
		logic [15:0]        new_ch;
		logic [15:0]        new_bits;
		logic [15:0]        kept_ch;
		logic [15:0]        kept_bits;
		wcp_pkg::status_t   err;

		function new();
			failures = 0;
			clear();
		endfunction

		function void clear();
			phase = wcp_pkg::PH_HEADER;
			hdr_cnt = 0;
			tag_cnt = 0;
			hdr_good = 1'b1;
			fmt_seen = 1'b0;
			pcm_present = 1'b0;
			tag = '0;
			len = '0;
			left = '0;
			new_rate = '0;
			kept_rate = '0;
			fmt_code = '0;
			new_ch = '0;
			new_bits = '0;
			kept_ch = '0;
			kept_bits = '0;
			err = wcp_pkg::ST_OK;
		endfunction

		function void open_chunk();
			phase = wcp_pkg::PH_CHUNK_HDR;
			tag_cnt = 0;
			tag = '0;
			len = '0;
		endfunction

		// A fmt chunk with a bad code is judged only here, at its last byte.
		function void close_chunk();
			if (tag == wcp_pkg::TAG_FMT) begin
				if (fmt_code != wcp_pkg::FMT_CODE_PCM) begin
					err = wcp_pkg::ST_UNSUPPORTED;
					return;
				end
				kept_ch = new_ch;
				kept_rate = new_rate;
				kept_bits = new_bits;
				fmt_seen = 1'b1;
			end else if (tag == wcp_pkg::TAG_DATA) begin
				pcm_present = (len != 0);
			end
			if (len[0])
				phase = wcp_pkg::PH_PAD;
			else
				open_chunk();
		endfunction

		function void push(wcp_pkg::kind_t kind, logic [7:0] b, logic restart,
				wcp_pkg::status_t st);
			expected_items.push_back(wcp_pkg::out_item_t'{item_kind: kind, pcm_byte: b,
				data_restart: restart, status: st, channel_count: kept_ch,
				rate_hz: kept_rate, sample_bits: kept_bits});
		endfunction

		function void take_byte(wcp_pkg::in_item_t it);
			logic [7:0]       b;
			logic [31:0]      off;
			wcp_pkg::status_t st;
			b = it.file_byte;
			if (err == wcp_pkg::ST_OK) begin
				case (phase)
				wcp_pkg::PH_HEADER: begin
					if (hdr_cnt < 4 && b != wcp_pkg::TAG_RIFF[31 - 8 * hdr_cnt -: 8])
						hdr_good = 1'b0;
					if (hdr_cnt >= 8 && b != wcp_pkg::TAG_WAVE[31 - 8 * (hdr_cnt - 8) -: 8])
						hdr_good = 1'b0;
					hdr_cnt++;
					if (hdr_cnt == 12) begin
						if (!hdr_good)
							err = wcp_pkg::ST_MALFORMED;
						else
							open_chunk();
					end
				end
				wcp_pkg::PH_CHUNK_HDR: begin
					if (tag_cnt < 4)
						tag = {tag[23:0], b};
					else
						len[8 * (tag_cnt - 4) +: 8] = b;
					tag_cnt++;
					if (tag_cnt == 8) begin
						left = len;
						if (tag == wcp_pkg::TAG_FMT && len < wcp_pkg::FMT_MIN_LEN)
							err = wcp_pkg::ST_MALFORMED;
						else if (len == 0)
							close_chunk();
						else
							phase = wcp_pkg::PH_BODY;
					end
				end
				wcp_pkg::PH_BODY: begin
					off = len - left;
					if (tag == wcp_pkg::TAG_FMT) begin
						if (off < 2)
							fmt_code[8 * off +: 8] = b;
						else if (off < 4)
							new_ch[8 * (off - 2) +: 8] = b;
						else if (off < 8)
							new_rate[8 * (off - 4) +: 8] = b;
						else if (off == 14 || off == 15)
							new_bits[8 * (off - 14) +: 8] = b;
					end else if (tag == wcp_pkg::TAG_DATA) begin
						push(wcp_pkg::KIND_PCM, b, off == 0, wcp_pkg::ST_OK);
					end
					left--;
					if (left == 0)
						close_chunk();
				end
				default: open_chunk();
				endcase
			end
			if (it.end_of_file) begin
				st = err;
				if (st == wcp_pkg::ST_OK) begin
					if (phase == wcp_pkg::PH_HEADER ||
					    (phase == wcp_pkg::PH_BODY && left != 0))
						st = wcp_pkg::ST_MALFORMED;
					else if (!fmt_seen || !pcm_present)
						st = wcp_pkg::ST_MALFORMED;
					else if (kept_bits != wcp_pkg::REQUIRED_BITS || kept_ch == 0 ||
					         kept_rate == 0)
						st = wcp_pkg::ST_UNSUPPORTED;
				end
				push(wcp_pkg::KIND_STATUS, 8'h00, 1'b0, st);
				clear();
			end
		endfunction

		function void compare(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected %0h, got %0h", field, want, got);
				failures++;
			end
		endfunction

		function void check_item(wcp_pkg::out_item_t got);
			wcp_pkg::out_item_t want;
			if (expected_items.size() == 0) begin
				$error("result item %h arrived with nothing expected", got);
				failures++;
				return;
			end
			want = expected_items.pop_front();
			compare("item_kind", want.item_kind, got.item_kind);
			compare("pcm_byte", want.pcm_byte, got.pcm_byte);
			compare("data_restart", want.data_restart, got.data_restart);
			compare("status", want.status, got.status);
			compare("channel_count", want.channel_count, got.channel_count);
			compare("rate_hz", want.rate_hz, got.rate_hz);
			compare("sample_bits", want.sample_bits, got.sample_bits);
		endfunction
	endclass

	localparam int SEND_IDLE[4]  = '{0, 71, 0, 8};
	localparam int RECV_STALL[4] = '{0, 0, 71, 8};
	localparam int PHASE_BYTES   = 325;

	logic               clk;
	logic               arst_n;
	logic               byte_valid;
	logic               byte_stall;
	wcp_pkg::in_item_t  byte_item;
	logic               result_valid;
	logic               result_stall;
	wcp_pkg::out_item_t result_item;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_left      = 0;
	int bytes_sent     = 0;

	wav_result_board board = new();

	wav_chunk_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_item(byte_item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_item(result_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Appends a chunk header and body_n random body bytes; the pad byte goes in only
	// when the whole body is there. Returns the index of the first body byte.
	function automatic int put_chunk(ref byte_q_t f, input logic [31:0] tag,
			input logic [31:0] len, input int body_n);
		int base;
		for (int k = 0; k < 4; k++)
			f.push_back(tag[31 - 8 * k -: 8]);
		for (int k = 0; k < 4; k++)
			f.push_back(len[8 * k +: 8]);
		base = f.size();
		repeat (body_n) f.push_back(8'($urandom));
		if (body_n == len && len[0])
			f.push_back(8'($urandom));
		return base;
	endfunction

	// A fmt chunk: the known fields are laid in little-endian, the rest stays random.
	function automatic void put_fmt(ref byte_q_t f, input logic [31:0] len,
			input logic [15:0] code, input logic [15:0] ch, input logic [31:0] rate,
			input logic [15:0] bits);
		int base;
		base = put_chunk(f, wcp_pkg::TAG_FMT, len, len);
		for (int j = 0; j < 16 && j < len; j++) begin
			case (j)
			0, 1:       f[base + j] = code[8 * j +: 8];
			2, 3:       f[base + j] = ch[8 * (j - 2) +: 8];
			4, 5, 6, 7: f[base + j] = rate[8 * (j - 4) +: 8];
			14, 15:     f[base + j] = bits[8 * (j - 14) +: 8];
			default: ;
			endcase
		end
	endfunction

	// Builds one file. With long_data set it is a clean file whose data chunk has
	// that many bytes; otherwise it is mostly well formed with random content, and
	// sometimes noise, a broken header, a cut-off chunk or trailing bytes.
	function automatic void make_file(ref byte_q_t f, input int long_data);
		int          n_chunks;
		int          r;
		int          cut;
		chunk_kind_t kind;
		logic [31:0] len;
		logic [31:0] rate;
		logic [31:0] tag;
		logic [15:0] code;
		logic [15:0] ch;
		logic [15:0] bits;
		bit          huge;
		f.delete();
		if (long_data == 0 && $urandom_range(99) < 5) begin
			repeat ($urandom_range(1, 20)) f.push_back(8'($urandom));
			return;
		end
		for (int k = 0; k < 4; k++)
			f.push_back(wcp_pkg::TAG_RIFF[31 - 8 * k -: 8]);
		repeat (4) f.push_back(8'($urandom));
		for (int k = 0; k < 4; k++)
			f.push_back(wcp_pkg::TAG_WAVE[31 - 8 * k -: 8]);
		if (long_data > 0) begin
			put_fmt(f, wcp_pkg::FMT_MIN_LEN, wcp_pkg::FMT_CODE_PCM, 16'd2, 32'd44100,
				wcp_pkg::REQUIRED_BITS);
			void'(put_chunk(f, wcp_pkg::TAG_DATA, long_data, long_data));
			return;
		end
		// A bad byte in the RIFF or WAVE tag.
		if ($urandom_range(15) == 0) begin
			r = $urandom_range(7);
			if (r >= 4)
				r += 4;
			f[r] ^= 8'($urandom_range(1, 255));
		end
		n_chunks = $urandom_range(1, 4);
		for (int i = 0; i < n_chunks; i++) begin
			r = $urandom_range(99);
			if (i == 0)
				kind = (r < 85) ? CK_FMT : (r < 95) ? CK_DATA : CK_OTHER;
			else
				kind = (r < 20) ? CK_FMT : (r < 75) ? CK_DATA : CK_OTHER;
			huge = ($urandom_range(99) < 4);
			r = $urandom_range(99);
			case (kind)
			CK_FMT: begin
				len = (r < 80) ? wcp_pkg::FMT_MIN_LEN : (r < 90) ? $urandom_range(17, 20)
					: $urandom_range(0, 15);
				code = ($urandom_range(99) < 90) ? wcp_pkg::FMT_CODE_PCM : 16'($urandom);
				r = $urandom_range(99);
				ch = (r < 80) ? 16'($urandom_range(1, 2)) : (r < 90) ? 16'd0 : 16'($urandom);
				r = $urandom_range(99);
				rate = (r < 35) ? 32'd44100 : (r < 70) ? 32'd8000 : (r < 80) ? 32'd0
					: 32'($urandom);
				r = $urandom_range(99);
				bits = (r < 80) ? wcp_pkg::REQUIRED_BITS : (r < 90) ? 16'd8
					: 16'($urandom);
				put_fmt(f, len, code, ch, rate, bits);
			end
			default: begin
				tag = (kind == CK_DATA) ? wcp_pkg::TAG_DATA : 32'($urandom);
				if (kind == CK_OTHER &&
				    (tag == wcp_pkg::TAG_FMT || tag == wcp_pkg::TAG_DATA))
					tag[0] = ~tag[0];
				// A declared length far beyond the end of the file.
				if (huge) begin
					void'(put_chunk(f, tag, 32'($urandom), $urandom_range(1, 20)));
					return;
				end
				if (kind == CK_OTHER)
					len = $urandom_range(0, 12);
				else
					len = (r < 15) ? 0 : (r < 85) ? $urandom_range(1, 24)
						: $urandom_range(25, 60);
				void'(put_chunk(f, tag, len, len));
			end
			endcase
		end
		r = $urandom_range(99);
		if (r < 15) begin
			repeat ($urandom_range(1, 7)) f.push_back(8'($urandom));
		end else if (r < 30) begin
			cut = $urandom_range(1, f.size());
			while (f.size() > cut)
				void'(f.pop_back());
		end else if (r < 35) begin
			void'(f.pop_back());
		end
	endfunction

	// Offers one byte from a falling edge and returns at the falling edge after the
	// transaction. Valid stays high into the next byte unless an idle cycle is drawn.
	task automatic send_byte(wcp_pkg::in_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(negedge clk);
		end
		byte_valid <= 1'b1;
		byte_item <= it;
		do @(posedge clk); while (byte_stall);
		board.take_byte(it);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_file(ref byte_q_t f);
		foreach (f[i])
			send_byte(wcp_pkg::in_item_t'{file_byte: f[i],
				end_of_file: (i == f.size() - 1)});
	endtask

	// The long hold-off of the receiver is counted down here.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0)
				hold_left--;
		end
	end

	initial begin
		result_stall <= 1'b0;
		forever begin
			@(negedge clk);
			result_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Every result transaction is checked against the oldest expected item.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && result_valid && !result_stall)
				board.check_item(result_item);
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		byte_q_t f;
		int      target;
		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		byte_item <= '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// A one-byte file, a header with a bad WAVE tag, and a good header with no
		// chunks after it.
		f = '{8'h00};
		send_file(f);
		f = '{8'h52, 8'h49, 8'h46, 8'h46, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			8'h57, 8'h41, 8'h56, 8'h00};
		send_file(f);
		f = '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h57, 8'h41, 8'h56, 8'h45};
		send_file(f);

		// The receiver holds off while a long data chunk keeps coming, so the result
		// queue fills and the byte channel has to stall.
		hold_left = 300;
		make_file(f, 64);
		send_file(f);

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = SEND_IDLE[p];
			recv_stall_pct = RECV_STALL[p];
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				make_file(f, 0);
				send_file(f);
			end
		end
		byte_valid <= 1'b0;

		while (board.expected_items.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
